[src/tia_pkg.sv]
// Package of the trapping integer ALU: action codes, trap codes and the item record
// that travels down the divider cell chain. It has no dependencies.
package tia_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned HalfWidth = 32;

   typedef enum logic [4:0] {
      ACT_ADD      = 5'd0,
      ACT_SUB      = 5'd1,
      ACT_MUL      = 5'd2,
      ACT_DIV_S    = 5'd3,
      ACT_DIV_U    = 5'd4,
      ACT_REM_S    = 5'd5,
      ACT_REM_U    = 5'd6,
      ACT_AND      = 5'd7,
      ACT_OR       = 5'd8,
      ACT_XOR      = 5'd9,
      ACT_SHL      = 5'd10,
      ACT_SHR_S    = 5'd11,
      ACT_SHR_U    = 5'd12,
      ACT_NEG      = 5'd13,
      ACT_EQ       = 5'd14,
      ACT_NE       = 5'd15,
      ACT_LT_S     = 5'd16,
      ACT_LE_S     = 5'd17,
      ACT_GT_S     = 5'd18,
      ACT_GE_S     = 5'd19,
      ACT_LT_U     = 5'd20,
      ACT_LE_U     = 5'd21,
      ACT_GT_U     = 5'd22,
      ACT_GE_U     = 5'd23,
      ACT_EXTEND_S = 5'd24,
      ACT_EXTEND_U = 5'd25,
      ACT_WRAP     = 5'd26
   } action_type;

   typedef enum logic [1:0] {
      TRAP_NONE     = 2'd0,
      TRAP_DIV_ZERO = 2'd1,
      TRAP_OVERFLOW = 2'd2
   } trap_type;

   // One item in flight: finished result for plain ops, divider state for div/rem.
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 want_rem;
      logic                 neg_q;
      logic                 neg_r;
      logic                 wide;
      trap_type             trap;
      logic [DataWidth-1:0] res;
      logic [DataWidth-1:0] rem;
      logic [DataWidth-1:0] dq;
      logic [DataWidth-1:0] dvs;
   } stage_type;

   function automatic logic [DataWidth-1:0] sext32(input logic [DataWidth-1:0] v);
      sext32 = {{HalfWidth{v[HalfWidth-1]}}, v[HalfWidth-1:0]};
   endfunction

endpackage

[src/trapping_integer_alu_32_64_top.sv]
// Trapping integer ALU, 32/64-bit. An item passes 67 register stages from the accepting edge
// to result shown: two front stages, 64 divider cells, one output register.
// Throughput: one item per cycle while the pipe advances; the chain of 64 restoring-division
// cells sets the latency, every operation travels through it so results stay in order.
// The whole pipe advances while the output register is empty or being taken.
// Reset (synchronous, active high) clears all valid flags; no other state.
module trapping_integer_alu_32_64_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [4:0]                    req_action,
   input  logic                          req_is_64,
   input  logic [tia_pkg::DataWidth-1:0] req_operand_a,
   input  logic [tia_pkg::DataWidth-1:0] req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tia_pkg::DataWidth-1:0] rsp_result_value,
   output logic [1:0]                    rsp_trap_code
);

   localparam int unsigned W     = tia_pkg::DataWidth;
   localparam int unsigned Cells = tia_pkg::DataWidth;

   tia_pkg::stage_type chain [Cells+1];

   logic         en;
   logic         rsp_valid_in, rsp_valid_ff;
   logic [W-1:0] rsp_value_in, rsp_value_ff, q, rm;
   logic [1:0]   rsp_trap_in, rsp_trap_ff;

   // advance everything when the output item is absent or being taken
   assign en        = rsp_ready || !rsp_valid_ff;
   assign req_ready = en;

   tia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_action (req_action),
      .in_is_64  (req_is_64),
      .in_a      (req_operand_a),
      .in_b      (req_operand_b),
      .out_stage (chain[0])
   );

   // one quotient bit per cell, most significant first
   for (genvar i = 0; i < Cells; i++) begin : g_cell
      tia_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   // finish: for div/rem apply signs to quotient or remainder and sign-extend 32-bit items, zero on trap
   always_comb begin
      q = chain[Cells].neg_q ? '0 - chain[Cells].dq  : chain[Cells].dq;
      rm = chain[Cells].neg_r ? '0 - chain[Cells].rem : chain[Cells].rem;
      rsp_valid_in = chain[Cells].valid;
      rsp_trap_in  = chain[Cells].trap;
      rsp_value_in = chain[Cells].res;
      if (chain[Cells].is_div) begin
         rsp_value_in = chain[Cells].want_rem ? rm : q;
         if (!chain[Cells].wide) begin
            rsp_value_in = tia_pkg::sext32(rsp_value_in);
         end
      end
      if (chain[Cells].trap != tia_pkg::TRAP_NONE) begin
         rsp_value_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_value_ff <= rsp_value_in;
         rsp_trap_ff  <= rsp_trap_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_trap_code    = rsp_trap_ff;

endmodule

[src/tia_front.sv]
// Front end of the trapping integer ALU: decodes the item, computes every plain
// result, the partial products of the multiply and the divider set-up. Uses tia_pkg.
module tia_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [4:0]                     in_action,
   input  logic                           in_is_64,
   input  logic [tia_pkg::DataWidth-1:0]  in_a,
   input  logic [tia_pkg::DataWidth-1:0]  in_b,
   output tia_pkg::stage_type             out_stage
);

   localparam int unsigned W = tia_pkg::DataWidth;
   localparam int unsigned H = tia_pkg::HalfWidth;

   tia_pkg::stage_type st_a_in, st_a_ff, st_b_in, st_b_ff;
   logic [W-1:0]       p0_in, p0_ff;
   logic [H-1:0]       p1_in, p1_ff, p2_in, p2_ff;
   logic               is_mul_in, is_mul_ff;

   logic [W-1:0] a, b, ua, ub, minv, r, mul_sum;
   logic [5:0]   sh;
   logic         narrow_fix, signed_div, na, nb;
   tia_pkg::action_type act;

   always_comb begin
      act        = tia_pkg::action_type'(in_action);
      a          = in_is_64 ? in_a : tia_pkg::sext32(in_a);
      b          = in_is_64 ? in_b : tia_pkg::sext32(in_b);
      ua         = in_is_64 ? in_a : {{H{1'b0}}, in_a[H-1:0]};
      ub         = in_is_64 ? in_b : {{H{1'b0}}, in_b[H-1:0]};
      minv       = in_is_64 ? {1'b1, {(W-1){1'b0}}} : {{(H+1){1'b1}}, {(H-1){1'b0}}};
      sh         = in_b[5:0] & (in_is_64 ? 6'd63 : 6'd31);
      narrow_fix = 1'b1;
      r          = '0;
      unique case (act)
         tia_pkg::ACT_ADD:   r = a + b;
         tia_pkg::ACT_SUB:   r = a - b;
         tia_pkg::ACT_AND:   r = a & b;
         tia_pkg::ACT_OR:    r = a | b;
         tia_pkg::ACT_XOR:   r = a ^ b;
         tia_pkg::ACT_SHL:   r = a << sh;
         tia_pkg::ACT_SHR_S: r = $unsigned($signed(a) >>> sh);
         tia_pkg::ACT_SHR_U: r = ua >> sh;
         tia_pkg::ACT_NEG:   r = '0 - a;
         tia_pkg::ACT_EQ:    r = W'(ua == ub);
         tia_pkg::ACT_NE:    r = W'(ua != ub);
         tia_pkg::ACT_LT_S:  r = W'($signed(a) <  $signed(b));
         tia_pkg::ACT_LE_S:  r = W'($signed(a) <= $signed(b));
         tia_pkg::ACT_GT_S:  r = W'($signed(a) >  $signed(b));
         tia_pkg::ACT_GE_S:  r = W'($signed(a) >= $signed(b));
         tia_pkg::ACT_LT_U:  r = W'(ua <  ub);
         tia_pkg::ACT_LE_U:  r = W'(ua <= ub);
         tia_pkg::ACT_GT_U:  r = W'(ua >  ub);
         tia_pkg::ACT_GE_U:  r = W'(ua >= ub);
         tia_pkg::ACT_EXTEND_S, tia_pkg::ACT_WRAP: begin
            r = tia_pkg::sext32(in_a);
            narrow_fix = 1'b0;
         end
         tia_pkg::ACT_EXTEND_U: begin
            r = {{H{1'b0}}, in_a[H-1:0]};
            narrow_fix = 1'b0;
         end
         default: r = '0;
      endcase
      if (!in_is_64 && narrow_fix) begin
         r = tia_pkg::sext32(r);
      end

      signed_div = (act == tia_pkg::ACT_DIV_S) || (act == tia_pkg::ACT_REM_S);
      na = signed_div && a[W-1];
      nb = signed_div && b[W-1];

      st_a_in          = '0;
      st_a_in.valid    = in_valid;
      st_a_in.wide     = in_is_64;
      st_a_in.res      = r;
      st_a_in.want_rem = (act == tia_pkg::ACT_REM_S) || (act == tia_pkg::ACT_REM_U);
      st_a_in.neg_q    = na ^ nb;
      st_a_in.neg_r    = na;
      st_a_in.dq       = signed_div ? (na ? '0 - a : a) : ua;
      st_a_in.dvs      = signed_div ? (nb ? '0 - b : b) : ub;
      st_a_in.trap     = tia_pkg::TRAP_NONE;
      if (signed_div || act == tia_pkg::ACT_DIV_U || act == tia_pkg::ACT_REM_U) begin
         if (ub == '0) begin
            st_a_in.trap = tia_pkg::TRAP_DIV_ZERO;
         end else if (signed_div && a == minv && b == '1) begin
            st_a_in.trap = tia_pkg::TRAP_OVERFLOW;
         end else begin
            st_a_in.is_div = 1'b1;
         end
      end

      // low 64 bits of the product from three 32x32 partial products
      is_mul_in = (act == tia_pkg::ACT_MUL);
      p0_in     = a[H-1:0] * b[H-1:0];
      p1_in     = H'(a[H-1:0] * b[W-1:H]);
      p2_in     = H'(a[W-1:H] * b[H-1:0]);

      mul_sum = p0_ff + {p1_ff + p2_ff, {H{1'b0}}};
      st_b_in = st_a_ff;
      if (is_mul_ff) begin
         st_b_in.res = st_a_ff.wide ? mul_sum : tia_pkg::sext32(mul_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_a_ff.valid <= 1'b0;
         st_b_ff.valid <= 1'b0;
      end else if (en) begin
         st_a_ff   <= st_a_in;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         is_mul_ff <= is_mul_in;
         st_b_ff   <= st_b_in;
      end
   end

   assign out_stage = st_b_ff;

endmodule

[src/tia_cell.sv]
// One cell of the divider chain: a single restoring divide step per item, registered.
// Uses tia_pkg.
module tia_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  tia_pkg::stage_type in_stage,
   output tia_pkg::stage_type out_stage
);

   localparam int unsigned W = tia_pkg::DataWidth;

   tia_pkg::stage_type st_in, st_ff;
   logic [W:0] trial, diff;

   always_comb begin
      trial = {in_stage.rem, in_stage.dq[W-1]};
      diff  = trial - {1'b0, in_stage.dvs};
      st_in = in_stage;
      // keep the trial remainder on a borrow, take the difference otherwise
      st_in.rem = diff[W] ? trial[W-1:0] : diff[W-1:0];
      st_in.dq  = {in_stage.dq[W-2:0], ~diff[W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_stage = st_ff;

endmodule

[tb/tb_trapping_integer_alu_32_64_top.sv]
// Testbench of the trapping 32/64-bit integer ALU: random and directed items with
// bursty sending and stalling on results, checked against a predictor in this file.
// Depends on tia_pkg and trapping_integer_alu_32_64_top.
module tb_trapping_integer_alu_32_64_top;

   typedef struct {
      logic [4:0]  action;
      logic        is_64;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } alu_op_type;

   typedef struct {
      logic [63:0] value;
      logic [1:0]  trap;
   } alu_res_type;

   localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MIN32 = 64'hFFFF_FFFF_8000_0000;
   localparam logic [4:0]  ActUnusedLow  = 5'd27;
   localparam logic [4:0]  ActUnusedHigh = 5'd31;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_action;
   logic        req_is_64;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_value;
   logic [1:0]  rsp_trap_code;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int          error_count = 0;
   bit          stimulus_done = 0;
   bit          hold_off_request = 0;
   bit          req_fire = 0;

   trapping_integer_alu_32_64_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_is_64        (req_is_64),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_trap_code    (rsp_trap_code)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] sign_extend_low(input logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   // Compute the result and trap code of one operation.
   function automatic alu_res_type compute_alu(input alu_op_type op);
      alu_res_type res;
      logic [63:0] a, b, ua, ub, minv, ma, mb, q;
      logic [6:0]  sh;
      bit          fix;
      a    = op.is_64 ? op.operand_a : sign_extend_low(op.operand_a);
      b    = op.is_64 ? op.operand_b : sign_extend_low(op.operand_b);
      ua   = op.is_64 ? op.operand_a : {32'd0, op.operand_a[31:0]};
      ub   = op.is_64 ? op.operand_b : {32'd0, op.operand_b[31:0]};
      minv = op.is_64 ? MIN64 : MIN32;
      sh   = op.is_64 ? {1'b0, b[5:0]} : {2'b0, b[4:0]};
      fix  = 1;
      res.value = '0;
      res.trap  = tia_pkg::TRAP_NONE;
      case (op.action)
         tia_pkg::ACT_ADD: res.value = a + b;
         tia_pkg::ACT_SUB: res.value = a - b;
         tia_pkg::ACT_MUL: res.value = a * b;
         tia_pkg::ACT_DIV_S, tia_pkg::ACT_DIV_U, tia_pkg::ACT_REM_S,
         tia_pkg::ACT_REM_U: begin
            if (ub == 0) begin
               res.trap = tia_pkg::TRAP_DIV_ZERO;
            end else if (op.action == tia_pkg::ACT_DIV_S ||
                         op.action == tia_pkg::ACT_REM_S) begin
               if (a == minv && b == '1) begin
                  res.trap = tia_pkg::TRAP_OVERFLOW;
               end else begin
                  ma = a[63] ? -a : a;
                  mb = b[63] ? -b : b;
                  if (op.action == tia_pkg::ACT_REM_S) begin
                     q = ma % mb;
                     res.value = a[63] ? -q : q;
                  end else begin
                     q = ma / mb;
                     res.value = (a[63] != b[63]) ? -q : q;
                  end
               end
            end else begin
               res.value = (op.action == tia_pkg::ACT_DIV_U) ? ua / ub : ua % ub;
            end
         end
         tia_pkg::ACT_AND:   res.value = a & b;
         tia_pkg::ACT_OR:    res.value = a | b;
         tia_pkg::ACT_XOR:   res.value = a ^ b;
         tia_pkg::ACT_SHL:   res.value = a << sh;
         tia_pkg::ACT_SHR_S: res.value = $signed(a) >>> sh;
         tia_pkg::ACT_SHR_U: res.value = ua >> sh;
         tia_pkg::ACT_NEG:   res.value = -a;
         tia_pkg::ACT_EQ:    res.value = 64'(ua == ub);
         tia_pkg::ACT_NE:    res.value = 64'(ua != ub);
         tia_pkg::ACT_LT_S:  res.value = 64'($signed(a) < $signed(b));
         tia_pkg::ACT_LE_S:  res.value = 64'($signed(a) <= $signed(b));
         tia_pkg::ACT_GT_S:  res.value = 64'($signed(a) > $signed(b));
         tia_pkg::ACT_GE_S:  res.value = 64'($signed(a) >= $signed(b));
         tia_pkg::ACT_LT_U:  res.value = 64'(ua < ub);
         tia_pkg::ACT_LE_U:  res.value = 64'(ua <= ub);
         tia_pkg::ACT_GT_U:  res.value = 64'(ua > ub);
         tia_pkg::ACT_GE_U:  res.value = 64'(ua >= ub);
         tia_pkg::ACT_EXTEND_S, tia_pkg::ACT_WRAP: begin
            res.value = sign_extend_low(op.operand_a);
            fix = 0;
         end
         tia_pkg::ACT_EXTEND_U: begin
            res.value = {32'd0, op.operand_a[31:0]};
            fix = 0;
         end
         default: res.value = '0;
      endcase
      if (res.trap != tia_pkg::TRAP_NONE) res.value = '0;
      else if (!op.is_64 && fix) res.value = sign_extend_low(res.value);
      return res;
   endfunction

   // Pick an operand biased towards the edge values that matter to each width.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return '1;
         2: return MIN64;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         4: return {$urandom(), 32'h8000_0000};
         5: return {$urandom(), 32'hFFFF_FFFF};
         6: return 64'($urandom_range(0, 70));
         7: return {$urandom(), 32'h7FFF_FFFF};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic queue_op(input logic [4:0] act, input logic w,
                           input logic [63:0] a, input logic [63:0] b);
      alu_op_type op;
      op.action = act;
      op.is_64 = w;
      op.operand_a = a;
      op.operand_b = b;
      pending_ops = {pending_ops, op};
   endtask

   // Fill the queue: directed edge cases first, then random items.
   initial begin
      logic [63:0] a, b;
      logic        w;
      queue_op(tia_pkg::ACT_DIV_S, 1, MIN64, '1);
      queue_op(tia_pkg::ACT_REM_S, 1, MIN64, '1);
      queue_op(tia_pkg::ACT_DIV_S, 0, 64'h1234_5678_8000_0000, 64'h0000_0000_FFFF_FFFF);
      queue_op(tia_pkg::ACT_REM_S, 0, 64'h0000_0000_8000_0000, 64'hABCD_0000_FFFF_FFFF);
      queue_op(tia_pkg::ACT_DIV_U, 1, 64'd5, 64'd0);
      queue_op(tia_pkg::ACT_REM_U, 0, 64'd5, 64'hFFFF_FFFF_0000_0000);
      queue_op(tia_pkg::ACT_DIV_S, 0, 64'd7, 64'h1_0000_0000);
      queue_op(tia_pkg::ACT_NEG, 0, 64'h0000_0001_8000_0000, '0);
      queue_op(tia_pkg::ACT_NEG, 1, MIN64, '0);
      queue_op(tia_pkg::ACT_EQ, 0, 64'hAAAA_0000_1234_5678, 64'h5555_0000_1234_5678);
      queue_op(tia_pkg::ACT_EXTEND_S, 1, 64'hFFFF_0000_8000_0001, '0);
      queue_op(tia_pkg::ACT_EXTEND_U, 0, 64'h1234_5678_FFFF_FFFF, '0);
      queue_op(tia_pkg::ACT_WRAP, 1, 64'h0000_0001_7FFF_FFFF, '0);
      queue_op(tia_pkg::ACT_SHL, 0, '1, 64'd33);
      queue_op(tia_pkg::ACT_SHR_S, 1, MIN64, 64'd127);
      queue_op(tia_pkg::ACT_SHR_U, 0, '1, 64'd32);
      queue_op(tia_pkg::ACT_ADD, 1, '1, '1);
      queue_op(tia_pkg::ACT_MUL, 0, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
      queue_op(tia_pkg::ACT_LT_S, 0, MIN32, 64'd1);
      queue_op(tia_pkg::ACT_GE_U, 1, '1, '0);
      queue_op(ActUnusedLow, 1, '1, '1);
      queue_op(ActUnusedHigh, 0, '1, '1);
      for (int i = 0; i < 1250; i++) begin
         w = 1'($urandom_range(0, 1));
         a = pick_operand();
         b = pick_operand();
         // Steer some operand pairs into the divide overflow case.
         if ($urandom_range(0, 15) == 0) begin
            a = w ? MIN64 : {$urandom(), 32'h8000_0000};
            b = w ? '1 : {$urandom(), 32'hFFFF_FFFF};
         end
         queue_op(5'($urandom_range(0, 31)), w, a, b);
      end
   end

   // Note each accepting edge for the driver.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
   end

   // Driver: burst of items, then sometimes a random gap; change inputs on the falling edge.
   always @(negedge clock) begin
      static int burst_left = 0;
      static int gap_left = 0;
      alu_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // hold the item until it is taken
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (pending_ops.size() == 0) begin
         req_valid <= 1'b0;
      end else begin
         if (burst_left == 0) burst_left = $urandom_range(1, 40);
         op = pending_ops.pop_front();
         req_action    <= op.action;
         req_is_64     <= op.is_64;
         req_operand_a <= op.operand_a;
         req_operand_b <= op.operand_b;
         req_valid     <= 1'b1;
         expected_results = {expected_results, compute_alu(op)};
         burst_left--;
         if (burst_left == 0 && $urandom_range(0, 2) != 0) gap_left = $urandom_range(1, 8);
      end
   end

   // Receiver stall pattern, with one long hold-off to fill the pipe and stall its input.
   always @(negedge clock) begin
      static int item_cycles = 0;
      static int hold_left = 0;
      static bit held = 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         item_cycles++;
         if (!held && item_cycles == 300) begin
            held = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if ((item_cycles / 64) % 3 == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Monitor: compare each result taken with the oldest expectation.
   always @(posedge clock) begin
      alu_res_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no item outstanding: value %h trap %0d",
                   rsp_result_value, rsp_trap_code);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_result_value !== exp_res.value) begin
               $error("result_value: expected %h, actual %h", exp_res.value, rsp_result_value);
               error_count++;
            end
            if (rsp_trap_code !== exp_res.trap) begin
               $error("trap_code: expected %0d, actual %0d", exp_res.trap, rsp_trap_code);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_action = '0;
      req_is_64 = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Drain: wait for all items to be sent and answered before the verdict.
      wait (pending_ops.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Timeout well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
